// ===== design/trapezoidal_rotation_ramp_unit_defines.svh =====
// shared assertion macros for the rotation ramp unit
`ifndef TRAPEZOIDAL_ROTATION_RAMP_UNIT_DEFINES_SVH
`define TRAPEZOIDAL_ROTATION_RAMP_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TRRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define TRRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/trru_pkg.sv =====
`default_nettype none

package trru_pkg;

    // profile constants
    localparam int RAMP_LEN  = 50;
    localparam int PERIOD_MS = 10;

    localparam logic [14:0] MAX_SPEED_RESET  = 15'd1024;
    localparam logic signed [15:0] HOLD_RESET = 16'sd1024;

    // register byte addresses
    localparam logic [1:0] ADDR_MAX_SPEED = 2'd0;

    // tick-count to speed scaling: mag * num / RAMP_LEN by reciprocal multiply
    localparam int RAMP_LOG     = $clog2(RAMP_LEN);
    localparam int NUM_W        = (RAMP_LOG > 0) ? RAMP_LOG : 1;
    localparam int RAMP_SHIFT   = 16 + 2 * RAMP_LOG;
    localparam logic [63:0] RAMP_RECIP =
        ((64'd1 << RAMP_SHIFT) + 64'(RAMP_LEN) - 64'd1) / 64'(RAMP_LEN);
    localparam int COEF_W       = 17 + 2 * RAMP_LOG;
    localparam int SCALE_PROD_W = 16 + COEF_W;

    // run time to tick count: run_time_ms / PERIOD_MS by reciprocal multiply
    localparam int PERIOD_LOG     = $clog2(PERIOD_MS);
    localparam int PERIOD_SHIFT   = 32 + PERIOD_LOG;
    localparam int PERIOD_RECIP_W = 33;
    localparam logic [63:0] PERIOD_RECIP =
        ((64'd1 << PERIOD_SHIFT) + 64'(PERIOD_MS) - 64'd1) / 64'(PERIOD_MS);
    localparam int DIV_PROD_W     = 32 + PERIOD_RECIP_W;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic signed [15:0] target_speed;
        logic [31:0]        run_time_ms;
    } item_t;

    typedef struct packed {
        logic signed [15:0] speed_out;
        logic               drive;
        logic               stop_motion;
        logic               done_res;
    } result_t;

    // ramp numerator premultiplied by the reciprocal of RAMP_LEN
    function automatic logic [COEF_W-1:0] ramp_coef(input logic [NUM_W-1:0] num);
        logic [63:0] prod;
        prod = 64'(num) * RAMP_RECIP;
        return prod[COEF_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/trapezoidal_rotation_ramp_unit.sv =====
// channel    | direction | transfer when      | payload
// s_ (items) | in        | s_valid & s_ready  | s_command, s_target_speed, s_run_time_ms
// m_ (speed) | out       | m_valid & m_ready  | m_speed_out, m_drive, m_stop_motion, m_done_res
// apb config | in        | psel&penable&pwrite| max_speed at byte address 0
//
// one item per cycle sustained while m_ready stays high; an accepted item passes through
// the input register, then speed compute and state update into the result register
// s_ready drops only while both registers hold items and m_ready is low
// aresetn is synchronous and active low; it clears handshake and profile state
`default_nettype none
`include "trapezoidal_rotation_ramp_unit_defines.svh"

module trapezoidal_rotation_ramp_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // item channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_command,
    input  wire logic signed [15:0] s_target_speed,
    input  wire logic [31:0]        s_run_time_ms,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_speed_out,
    output logic                    m_drive,
    output logic                    m_stop_motion,
    output logic                    m_done_res,
    // config port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    logic              in_valid_reg,  in_valid_next;
    trru_pkg::item_t   item_reg,      item_next;
    logic              out_valid_reg, out_valid_next;
    trru_pkg::result_t result_reg,    result_next;
    logic              advance;
    logic [14:0]       max_speed;

    trru_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_speed (max_speed)
    );

    trru_profile_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (item_reg),
        .max_speed (max_speed),
        .result    (result_next)
    );

    // pipeline flow control
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            item_next     = '{command:      trru_pkg::cmd_t'(s_command),
                              target_speed: s_target_speed,
                              run_time_ms:  s_run_time_ms};
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload flops
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_speed_out   = result_reg.speed_out;
    assign m_drive       = result_reg.drive;
    assign m_stop_motion = result_reg.stop_motion;
    assign m_done_res    = result_reg.done_res;

    `TRRU_ASSERT_NEXT(a_step_fills_result, advance, out_valid_reg,
        "computed item did not reach the result register")
    `TRRU_ASSERT_NOW(a_drive_excludes_stop, out_valid_reg && m_drive, !m_stop_motion && !m_done_res,
        "drive together with stop or done")
    `TRRU_ASSERT_NOW(a_idle_speed_zero, out_valid_reg && !m_drive, m_speed_out == 16'sd0,
        "nonzero speed without drive")
    `TRRU_ASSERT_NOW(a_stop_means_done, out_valid_reg && m_stop_motion, m_done_res,
        "stop issued while still running")

endmodule

`default_nettype wire

// ===== design/trru_cfg_regs.sv =====
`default_nettype none

module trru_cfg_regs (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [14:0] max_speed
);

    logic [14:0] max_speed_reg;
    logic [14:0] max_speed_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == trru_pkg::ADDR_MAX_SPEED);

    // register write on the access phase
    always_comb begin
        max_speed_next = max_speed_reg;
        if (wr_en) begin
            max_speed_next = pwdata[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= trru_pkg::MAX_SPEED_RESET;
        end else begin
            max_speed_reg <= max_speed_next;
        end
    end

    // read back
    always_comb begin
        prdata = 32'd0;
        if (paddr == trru_pkg::ADDR_MAX_SPEED) begin
            prdata = {17'd0, max_speed_reg};
        end
    end

    assign max_speed = max_speed_reg;

endmodule

`default_nettype wire

// ===== design/trru_profile_core.sv =====
`default_nettype none
`include "trapezoidal_rotation_ramp_unit_defines.svh"

module trru_profile_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire trru_pkg::item_t  item,
    input  wire logic [14:0]      max_speed,
    output trru_pkg::result_t     result
);

    logic               running_reg,    running_next;
    logic [31:0]        tick_count_reg, tick_count_next;
    logic [31:0]        total_ticks_reg, total_ticks_next;
    logic signed [15:0] hold_speed_reg, hold_speed_next;

    // start path: clamp and tick total
    logic signed [15:0] lim;
    logic signed [15:0] neg_lim;
    logic signed [15:0] clamped;
    logic [trru_pkg::DIV_PROD_W-1:0] div_prod;
    logic [31:0]        ticks_quo;
    logic [31:0]        ticks_total;

    always_comb begin
        lim     = $signed({1'b0, max_speed});
        neg_lim = -lim;
        clamped = item.target_speed;
        if (item.target_speed > lim) begin
            clamped = lim;
        end else if (item.target_speed < neg_lim) begin
            clamped = neg_lim;
        end
        div_prod = trru_pkg::DIV_PROD_W'(item.run_time_ms)
                 * trru_pkg::DIV_PROD_W'(trru_pkg::PERIOD_RECIP);
        ticks_quo   = 32'(div_prod >> trru_pkg::PERIOD_SHIFT);
        ticks_total = (ticks_quo == 32'd0) ? 32'd1 : ticks_quo;
    end

    // tick path: phase select and scaled speed
    logic                             at_end;
    logic                             in_rise;
    logic                             in_fall;
    logic [trru_pkg::NUM_W-1:0]       num;
    logic [15:0]                      mag;
    logic [trru_pkg::SCALE_PROD_W-1:0] scale_prod;
    logic [15:0]                      scaled_mag;
    logic signed [15:0]               scaled;
    logic signed [15:0]               tick_speed;

    always_comb begin
        at_end  = tick_count_reg >= total_ticks_reg;
        in_rise = tick_count_reg < 32'(trru_pkg::RAMP_LEN);
        in_fall = tick_count_reg > (total_ticks_reg - 32'(trru_pkg::RAMP_LEN));
        num     = in_rise ? trru_pkg::NUM_W'(tick_count_reg)
                          : trru_pkg::NUM_W'(total_ticks_reg - tick_count_reg);
        mag     = hold_speed_reg[15] ? $unsigned(-hold_speed_reg) : $unsigned(hold_speed_reg);
        scale_prod = trru_pkg::SCALE_PROD_W'(mag)
                   * trru_pkg::SCALE_PROD_W'(trru_pkg::ramp_coef(num));
        scaled_mag = 16'(scale_prod >> trru_pkg::RAMP_SHIFT);
        scaled     = hold_speed_reg[15] ? -$signed(scaled_mag) : $signed(scaled_mag);
        tick_speed = (in_rise || in_fall) ? scaled : hold_speed_reg;
    end

    // command decode and next state
    logic signed [15:0] speed;
    logic               drive;
    logic               stop_motion;

    always_comb begin
        running_next     = running_reg;
        tick_count_next  = tick_count_reg;
        total_ticks_next = total_ticks_reg;
        hold_speed_next  = hold_speed_reg;
        speed            = 16'sd0;
        drive            = 1'b0;
        stop_motion      = 1'b0;
        unique case (item.command)
            trru_pkg::CMD_START: begin
                hold_speed_next  = clamped;
                total_ticks_next = ticks_total;
                tick_count_next  = 32'd0;
                running_next     = 1'b1;
            end
            trru_pkg::CMD_STOP: begin
                running_next = 1'b0;
                stop_motion  = 1'b1;
            end
            trru_pkg::CMD_TICK: begin
                if (running_reg) begin
                    if (at_end) begin
                        stop_motion  = 1'b1;
                        running_next = 1'b0;
                    end else begin
                        speed           = tick_speed;
                        drive           = 1'b1;
                        tick_count_next = tick_count_reg + 32'd1;
                    end
                end
            end
            trru_pkg::CMD_NONE: begin
                running_next = running_reg;
            end
            default: begin
                running_next = running_reg;
            end
        endcase
    end

    assign result.speed_out   = speed;
    assign result.drive       = drive;
    assign result.stop_motion = stop_motion;
    assign result.done_res    = !running_next;

    // state update, one item per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg     <= 1'b0;
            tick_count_reg  <= 32'd0;
            total_ticks_reg <= 32'd0;
            hold_speed_reg  <= trru_pkg::HOLD_RESET;
        end else if (step) begin
            running_reg     <= running_next;
            tick_count_reg  <= tick_count_next;
            total_ticks_reg <= total_ticks_next;
            hold_speed_reg  <= hold_speed_next;
        end
    end

    // a run always has at least one tick and never counts past its total
    `TRRU_ASSERT_NOW(a_run_total_nonzero, running_reg, total_ticks_reg != 32'd0,
        "running with a zero tick total")
    `TRRU_ASSERT_NOW(a_count_within_total, running_reg, tick_count_reg <= total_ticks_reg,
        "tick counter passed the total")

endmodule

`default_nettype wire

// ===== tb/trapezoidal_rotation_ramp_unit_tb.sv =====
import trru_pkg::*;

// spin profile predictor plus queue of speed commands still due
class spin_ramp_scoreboard;
    bit [14:0]          speed_limit;
    bit                 ramp_active;
    bit [31:0]          ticks_done;
    bit [31:0]          ticks_total;
    logic signed [15:0] spin_speed;
    result_t            speed_cmds_due[$];
    int                 mismatches;
    int                 checked;

    function new();
        speed_limit = MAX_SPEED_RESET;
        ramp_active = 1'b0;
        ticks_done  = '0;
        ticks_total = '0;
        spin_speed  = HOLD_RESET;
        mismatches  = 0;
        checked     = 0;
    endfunction

    // fraction num/RAMP_LEN of the held speed, truncated toward zero
    function logic signed [15:0] ramp_fraction(logic signed [15:0] s, bit [31:0] num);
        longint mag;
        longint q;
        mag = (s < 0) ? -longint'(s) : longint'(s);
        q = (mag * longint'(num)) / RAMP_LEN;
        return (s < 0) ? 16'(-q) : 16'(q);
    endfunction

    // advance the profile on one input transfer and queue its speed command
    function void accept_item(cmd_t cmd, logic signed [15:0] tgt, logic [31:0] dur);
        result_t r;
        int      t;
        int      lim;
        bit [31:0] n;
        r = '0;
        case (cmd)
            CMD_START: begin
                t = int'(tgt);
                lim = int'(speed_limit);
                if (t > lim) t = lim;
                if (t < -lim) t = -lim;
                n = dur / PERIOD_MS;
                if (n == 0) n = 1;
                spin_speed  = 16'(t);
                ticks_total = n;
                ticks_done  = '0;
                ramp_active = 1'b1;
            end
            CMD_STOP: begin
                ramp_active   = 1'b0;
                r.stop_motion = 1'b1;
            end
            CMD_TICK: begin
                if (ramp_active) begin
                    if (ticks_done >= ticks_total) begin
                        r.stop_motion = 1'b1;
                        ramp_active   = 1'b0;
                    end else begin
                        // ramp-up wins over ramp-down; the down test wraps at 32 bits
                        if (ticks_done < RAMP_LEN)
                            r.speed_out = ramp_fraction(spin_speed, ticks_done);
                        else if (ticks_done > ticks_total - 32'(RAMP_LEN))
                            r.speed_out = ramp_fraction(spin_speed, ticks_total - ticks_done);
                        else
                            r.speed_out = spin_speed;
                        r.drive = 1'b1;
                        ticks_done++;
                    end
                end
            end
            default: ;
        endcase
        r.done_res = !ramp_active;
        speed_cmds_due.push_back(r);
    endfunction

    // compare one result transfer with the oldest due command
    function void check_result(result_t got);
        result_t exp;
        if (speed_cmds_due.size() == 0) begin
            $display("%0t: unexpected result speed_out %0d drive %0b stop %0b done %0b",
                     $time, got.speed_out, got.drive, got.stop_motion, got.done_res);
            mismatches++;
            return;
        end
        exp = speed_cmds_due.pop_front();
        checked++;
        if (got.speed_out !== exp.speed_out) begin
            $display("%0t: speed_out expected %0d actual %0d", $time, exp.speed_out,
                     got.speed_out);
            mismatches++;
        end
        if (got.drive !== exp.drive) begin
            $display("%0t: drive expected %0b actual %0b", $time, exp.drive, got.drive);
            mismatches++;
        end
        if (got.stop_motion !== exp.stop_motion) begin
            $display("%0t: stop_motion expected %0b actual %0b", $time, exp.stop_motion,
                     got.stop_motion);
            mismatches++;
        end
        if (got.done_res !== exp.done_res) begin
            $display("%0t: done_res expected %0b actual %0b", $time, exp.done_res,
                     got.done_res);
            mismatches++;
        end
    endfunction

    function int pending();
        return speed_cmds_due.size();
    endfunction
endclass

module trapezoidal_rotation_ramp_unit_tb;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command      = CMD_TICK;
    logic signed [15:0] s_target_speed = '0;
    logic [31:0]        s_run_time_ms  = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic signed [15:0] m_speed_out;
    logic               m_drive;
    logic               m_stop_motion;
    logic               m_done_res;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [1:0]         paddr          = ADDR_MAX_SPEED;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;

    spin_ramp_scoreboard sb = new();
    int sent_count = 0;

    trapezoidal_rotation_ramp_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_target_speed (s_target_speed),
        .s_run_time_ms  (s_run_time_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_speed_out    (m_speed_out),
        .m_drive        (m_drive),
        .m_stop_motion  (m_stop_motion),
        .m_done_res     (m_done_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 aclk = ~aclk;

    // offer one item, with random gaps outside the gap-free stretch
    task automatic send_item(input cmd_t cmd, input logic signed [15:0] tgt,
                             input logic [31:0] dur);
        if (!(sent_count >= 200 && sent_count < 600)) begin
            while ($urandom_range(0, 99) < 15) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_target_speed <= tgt;
        s_run_time_ms  <= dur;
        do @(posedge aclk); while (!s_ready);
        sb.accept_item(cmd, tgt, dur);
        sent_count++;
        @(negedge aclk);
    endtask

    // let every due result arrive, then a few cycles of margin
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // apb write of max_speed followed by a readback
    task automatic write_max_speed(input logic [14:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_SPEED;
        pwdata  <= {17'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.speed_limit = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[14:0] !== value) begin
            $display("%0t: max_speed readback expected %0d actual %0d", $time, value,
                     readback[14:0]);
            sb.mismatches++;
        end
    endtask

    // mostly complete ramp runs with random content, some early stops and noise
    task automatic run_random(input int n_items);
        int                 base;
        int                 n_ticks;
        int                 dur_sel;
        bit                 stop_early;
        logic [31:0]        dur;
        logic signed [15:0] tgt;
        base = sent_count;
        // carry on any profile left running across the register write
        repeat ($urandom_range(3, 20)) send_item(CMD_TICK, 16'($urandom), $urandom);
        while (sent_count - base < n_items) begin
            if ($urandom_range(0, 99) < 80) begin
                case ($urandom_range(0, 9))
                    0: tgt = 16'sh8000;
                    1: tgt = 16'sh7fff;
                    default: tgt = 16'($urandom);
                endcase
                dur_sel = $urandom_range(0, 99);
                if (dur_sel < 30) dur = $urandom_range(0, 499);
                else if (dur_sel < 70) dur = $urandom_range(500, 1309);
                else if (dur_sel < 90) dur = $urandom_range(1310, 2509);
                else dur = $urandom;
                send_item(CMD_START, tgt, dur);
                n_ticks = (dur / PERIOD_MS > 250) ? 250 : dur / PERIOD_MS;
                if (n_ticks == 0) n_ticks = 1;
                n_ticks = n_ticks + 1 + $urandom_range(0, 2);
                stop_early = ($urandom_range(0, 99) < 15);
                if (stop_early) n_ticks = $urandom_range(0, n_ticks);
                repeat (n_ticks) begin
                    if ($urandom_range(0, 99) < 4)
                        send_item(CMD_NONE, 16'($urandom), $urandom);
                    send_item(CMD_TICK, 16'($urandom), $urandom);
                end
                if (stop_early) send_item(CMD_STOP, 16'($urandom), $urandom);
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item(cmd_t'($urandom_range(0, 3)), 16'($urandom), $urandom);
            end
        end
    endtask

    // receiver: random stalls, a gap-free stretch and two long hold-offs
    initial begin
        int       hold_left;
        bit [1:0] holds_done;
        hold_left  = 0;
        holds_done = '0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && !holds_done[0] && sb.checked >= 100) begin
                holds_done[0] = 1'b1;
                hold_left = 300;
            end else if (hold_left == 0 && !holds_done[1] && sb.checked >= 1500) begin
                holds_done[1] = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (sb.checked >= 200 && sb.checked < 600) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // result transfer monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_speed_out, m_drive, m_stop_motion, m_done_res});
    end

    // watchdog
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // stimulus
    initial begin
        int wait_cycles;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // idle-state commands
        send_item(CMD_TICK, 16'sd0, 32'd0);
        send_item(CMD_STOP, -16'sd1, 32'hffff_ffff);
        send_item(CMD_NONE, 16'sh7fff, 32'h5555_aaaa);
        // most negative target clamps, zero duration gives one tick
        send_item(CMD_START, 16'sh8000, 32'd0);
        send_item(CMD_TICK, 16'sd0, 32'd0);
        send_item(CMD_TICK, 16'sd0, 32'd0);
        // largest target, duration below one period
        send_item(CMD_START, 16'sh7fff, 32'd9);
        send_item(CMD_NONE, 16'sd0, 32'd0);
        send_item(CMD_TICK, 16'sd0, 32'd0);
        send_item(CMD_TICK, 16'sd0, 32'd0);
        send_item(CMD_TICK, 16'sd0, 32'd0);
        // largest duration, halted by a stop
        send_item(CMD_START, 16'sd1023, 32'hffff_ffff);
        repeat (3) send_item(CMD_TICK, 16'sd0, 32'd0);
        send_item(CMD_STOP, 16'sd0, 32'd0);
        send_item(CMD_START, -16'sd1, 32'd10);
        send_item(CMD_TICK, 16'sd0, 32'd0);
        send_item(CMD_TICK, 16'sd0, 32'd0);
        // restart while running
        send_item(CMD_START, 16'sd1024, 32'd20);
        send_item(CMD_TICK, 16'sd0, 32'd0);
        send_item(CMD_START, 16'sd0, 32'd30);
        send_item(CMD_TICK, 16'sd0, 32'd0);
        wait_idle();

        write_max_speed(15'h7fff);
        run_random(600);
        wait_idle();
        write_max_speed(15'd0);
        run_random(300);
        wait_idle();
        write_max_speed(15'($urandom_range(1, 32766)));
        run_random(600);
        wait_idle();
        write_max_speed(15'($urandom_range(1, 60)));
        run_random(500);

        // drain
        s_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 2000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (10) @(negedge aclk);
        if (sb.pending() != 0)
            $display("%0t: %0d results never arrived", $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
